// ===== design/ahob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahob_pkg
// Shared types, constants and the sine table for the harmonic oscillator bank.
// ----------------------------------------------------------------------------
package ahob_pkg;

  localparam int MAX_HARMONICS  = 128;
  localparam int HIDX_W         = $clog2(MAX_HARMONICS);
  localparam int KCNT_W         = $clog2(MAX_HARMONICS + 1);
  localparam int SINE_ADDR_BITS = 10;
  localparam int ROM_DEPTH      = 1 << SINE_ADDR_BITS;
  localparam int QUARTER_SZ     = ROM_DEPTH / 4;
  localparam int ACC_W          = 24;
  localparam int LIMIT_W        = 8;
  localparam int LIMIT_RESET    = 100;
  localparam int AMP_RESET_VAL  = 9830;
  localparam int AMP_RESET_IDX  = 99;

  // Harmonic k is summed while (k+1) * 9 * (inc >> 16) stays at or below this.
  localparam int ALIAS_NUM = 262144;
  localparam int DSTEP_W   = 20;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [15:0]      smp_t;
  typedef smp_t                    sine_tab_t [ROM_DEPTH];

  typedef struct packed {
    logic        req_type;
    logic [31:0] phase_inc;
    logic        octave_down;
    logic [1:0]  mix_mode;
    logic [6:0]  coef_index;
    logic signed [15:0] coef_value;
  } ahob_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } ahob_out_t;

  typedef struct packed {
    logic              amp_wr;
    logic              load;
    logic              issue;
    logic [HIDX_W-1:0] issue_idx;
    logic              mix_mul;
    logic              left_sel;
    logic              shape_go;
    logic              shape_sel;
    logic              out_load;
  } ahob_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic shape_done;
    logic out_free;
  } ahob_sts_t;

  function automatic smp_t quarter_sine(input int unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    x  = (HALF_PI_Q30 * longint'(j)) / QUARTER_SZ;
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    for (int n = 0; n < 5; n++) begin
      r = ONE_Q30 - (((x2 * r) >> 30) / TAYLOR_DIV[n]);
    end
    s = (x * r) >> 30;
    return 16'((s * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic sine_tab_t ahob_sine_table();
    sine_tab_t   tab;
    int unsigned quad;
    int unsigned j;
    smp_t        v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      quad = i / QUARTER_SZ;
      j    = i % QUARTER_SZ;
      v    = quad[0] ? quarter_sine(QUARTER_SZ - j) : quarter_sine(j);
      tab[i] = quad[1] ? -v : v;
    end
    return tab;
  endfunction

  function automatic acc_t sat_acc(input logic signed [47:0] v);
    if (v > 48'sd8388607) return acc_t'(24'sh7FFFFF);
    if (v < -48'sd8388608) return acc_t'(24'sh800000);
    return acc_t'(v[ACC_W-1:0]);
  endfunction

  function automatic logic signed [15:0] amp_reset(input logic [HIDX_W-1:0] idx);
    if (int'(idx) == 0 || int'(idx) == AMP_RESET_IDX) return 16'(AMP_RESET_VAL);
    return '0;
  endfunction

endpackage

// ===== design/ahob_tanh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahob_tanh
// Multi-cycle 7/6 Pade tanh with Q1.15 saturation, one shared multiplier and
// a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ahob_tanh
  import ahob_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  acc_t        x,
  output logic        done,
  output smp_t        y
);

  typedef enum logic [9:0] {
    T_IDLE = 10'b0000000001,
    T_X2   = 10'b0000000010,
    T_P2   = 10'b0000000100,
    T_P3   = 10'b0000001000,
    T_P    = 10'b0000010000,
    T_Q2   = 10'b0000100000,
    T_Q3   = 10'b0001000000,
    T_CHK  = 10'b0010000000,
    T_DIV  = 10'b0100000000,
    T_FIN  = 10'b1000000000
  } tstate_t;

  localparam logic [37:0] K_P1   = 38'(64'd378 << 16);
  localparam logic [31:0] K_P2   = 32'(64'd17325 << 16);
  localparam logic [37:0] K_P3   = 38'(64'd135135 << 16);
  localparam logic [28:0] K_Q1   = 29'(64'd3150 << 16);
  localparam logic [34:0] K_Q2   = 35'(64'd62370 << 16);
  localparam logic [40:0] K_Q3   = 41'(64'd135135 << 16);
  localparam logic [23:0] M_CLIP = 24'(64'd8 << 16);

  tstate_t      state_r, state_nxt;
  logic         neg_r;
  logic [19:0]  m_r;
  logic [22:0]  x2_r;
  logic [31:0]  p2_r;
  logic [37:0]  p3_r;
  logic [56:0]  p_r;
  logic [34:0]  q2_r;
  logic [41:0]  den_r;
  logic [56:0]  rem_r;
  logic [56:0]  dsh_r;
  logic         sat_r;
  logic [14:0]  quo_r;
  logic [3:0]   cnt_r;

  logic [37:0]  op_a;
  logic [22:0]  op_b;
  logic [60:0]  prod;
  logic [28:0]  q1;
  logic [23:0]  mag;
  logic [15:0]  ymag;

  assign q1   = 29'({x2_r, 5'b0}) - 29'({x2_r, 2'b0}) + K_Q1;
  assign mag  = x[ACC_W-1] ? 24'(-x) : 24'(x);
  assign ymag = sat_r ? (neg_r ? 16'h8000 : 16'h7FFF) : {1'b0, quo_r};

  always_comb begin
    op_a = 38'(m_r);
    op_b = 23'(m_r);
    unique case (state_r)
      T_P2:    begin op_a = K_P1 + 38'(x2_r); op_b = x2_r; end
      T_P3:    begin op_a = 38'(p2_r);        op_b = x2_r; end
      T_P:     begin op_a = p3_r;             op_b = 23'(m_r); end
      T_Q2:    begin op_a = 38'(q1);          op_b = x2_r; end
      T_Q3:    begin op_a = 38'(q2_r);        op_b = x2_r; end
      default: begin op_a = 38'(m_r);         op_b = 23'(m_r); end
    endcase
  end

  assign prod = 61'(op_a) * 61'(op_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (start) state_nxt = T_X2;
      T_X2:    state_nxt = T_P2;
      T_P2:    state_nxt = T_P3;
      T_P3:    state_nxt = T_P;
      T_P:     state_nxt = T_Q2;
      T_Q2:    state_nxt = T_Q3;
      T_Q3:    state_nxt = T_CHK;
      T_CHK:   state_nxt = T_DIV;
      T_DIV:   if (cnt_r == 4'd0) state_nxt = T_FIN;
      T_FIN:   state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE: begin
        neg_r <= x[ACC_W-1];
        m_r   <= (mag > M_CLIP) ? M_CLIP[19:0] : mag[19:0];
      end
      T_X2:  x2_r <= prod[38:16];
      T_P2:  p2_r <= prod[47:16] + K_P2;
      T_P3:  p3_r <= prod[53:16] + K_P3;
      T_P:   p_r  <= prod[56:0];
      T_Q2:  q2_r <= prod[50:16] + K_Q2;
      T_Q3:  den_r <= {prod[56:16] + K_Q3, 1'b0};
      T_CHK: begin
        // A quotient of 2^15 or more saturates either way.
        sat_r <= (p_r >= {den_r, 15'b0});
        rem_r <= p_r;
        dsh_r <= 57'({den_r, 14'b0});
        cnt_r <= 4'd14;
        quo_r <= '0;
      end
      T_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[13:0], 1'b1};
        end else begin
          quo_r <= {quo_r[13:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  assign done = (state_r == T_FIN);
  assign y    = neg_r ? smp_t'(-ymag) : smp_t'(ymag);

endmodule

// ===== design/ahob_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahob_dp
// Datapath: phase and amplitude memories, four-stage harmonic pipeline,
// even/odd mixes, left mix selection, tanh shaping and the result register.
// ----------------------------------------------------------------------------
module ahob_dp
  import ahob_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ahob_cmd_t cmd,
  input  ahob_in_t  in_data,
  output ahob_sts_t sts,
  output logic      out_valid,
  input  logic      out_ready,
  output ahob_out_t out_data
);

  localparam sine_tab_t SINE_TAB = ahob_sine_table();

  logic [31:0]        phase_mem [MAX_HARMONICS];
  logic signed [15:0] amp_mem   [MAX_HARMONICS];
  logic [MAX_HARMONICS-1:0] ph_vld_r;
  logic [MAX_HARMONICS-1:0] amp_vld_r;

  logic [31:0] inc_r;
  logic [31:0] step_r;
  logic [1:0]  mode_r;
  acc_t        mix0_r, mix1_r;
  acc_t        left_r;
  logic signed [47:0] ringp_r;

  // Stage 1: memory read data.
  logic              s1_v_r;
  logic [HIDX_W-1:0] s1_k_r;
  logic [31:0]       s1_step_r;
  logic [31:0]       ph_rd_r;
  logic              phv_r;
  logic signed [15:0] amp_rd_r;
  logic              ampv_r;
  // Stage 2: sine and amplitude.
  logic              s2_v_r;
  logic              s2_par_r;
  smp_t              s2_sin_r;
  logic signed [15:0] s2_amp_r;
  // Stage 3: weighted partial.
  logic              s3_v_r;
  logic              s3_par_r;
  logic signed [31:0] s3_prod_r;

  logic [31:0]  new_ph;
  logic [31:0]  inc_in;
  logic signed [17:0] part;
  acc_t         mix_sel, mix_upd;
  acc_t         left_nxt;
  logic         wr_ok;

  logic         sh_sel_r;
  smp_t         yl_r, yr_r;
  logic         sh_done;
  smp_t         sh_y;
  logic         out_valid_r;
  ahob_out_t    out_data_r;

  assign inc_in  = in_data.octave_down ? (in_data.phase_inc >> 1) : in_data.phase_inc;
  assign new_ph  = (phv_r ? ph_rd_r : 32'd0) + s1_step_r;
  assign wr_ok   = (int'(in_data.coef_index) < MAX_HARMONICS);
  assign part    = 18'(s3_prod_r >>> 14);
  assign mix_sel = s3_par_r ? mix1_r : mix0_r;
  assign mix_upd = sat_acc(48'(mix_sel) + 48'(part));

  always_comb begin
    priority if (mode_r[1]) begin
      left_nxt = sat_acc(ringp_r >>> 16);
    end else if (mode_r[0]) begin
      left_nxt = sat_acc(48'(mix0_r) + 48'(mix1_r));
    end else begin
      left_nxt = mix0_r;
    end
  end

  // Memories: one read port at the issue index, one write port.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ph_rd_r  <= phase_mem[cmd.issue_idx];
      amp_rd_r <= amp_mem[cmd.issue_idx];
    end
    if (s1_v_r) begin
      phase_mem[s1_k_r] <= new_ph;
    end
    if (cmd.amp_wr && wr_ok) begin
      amp_mem[HIDX_W'(in_data.coef_index)] <= in_data.coef_value;
    end
  end

  // An entry never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_vld_r  <= '0;
      amp_vld_r <= '0;
    end else begin
      if (s1_v_r) ph_vld_r[s1_k_r] <= 1'b1;
      if (cmd.amp_wr && wr_ok) amp_vld_r[HIDX_W'(in_data.coef_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inc_r  <= inc_in;
      step_r <= inc_in;
      mode_r <= in_data.mix_mode;
      mix0_r <= '0;
      mix1_r <= '0;
    end else begin
      if (cmd.issue) step_r <= step_r + inc_r;
      if (s3_v_r) begin
        if (s3_par_r) mix1_r <= mix_upd;
        else          mix0_r <= mix_upd;
      end
    end
    if (cmd.issue) begin
      s1_k_r    <= cmd.issue_idx;
      s1_step_r <= step_r;
      phv_r     <= ph_vld_r[cmd.issue_idx];
      ampv_r    <= amp_vld_r[cmd.issue_idx];
    end
    s2_sin_r  <= SINE_TAB[new_ph[31 -: SINE_ADDR_BITS]];
    s2_amp_r  <= ampv_r ? amp_rd_r : amp_reset(s1_k_r);
    s2_par_r  <= s1_k_r[0];
    s3_prod_r <= 32'(s2_sin_r) * 32'(s2_amp_r);
    s3_par_r  <= s2_par_r;
    if (cmd.mix_mul)  ringp_r <= 48'(mix0_r) * 48'(mix1_r);
    if (cmd.left_sel) left_r  <= left_nxt;
    if (cmd.shape_go) sh_sel_r <= cmd.shape_sel;
    if (sh_done) begin
      if (sh_sel_r) yr_r <= sh_y;
      else          yl_r <= sh_y;
    end
  end

  ahob_tanh u_tanh (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.shape_go),
    .x     (cmd.shape_sel ? mix1_r : left_r),
    .done  (sh_done),
    .y     (sh_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.left_sample  <= yl_r;
      out_data_r.right_sample <= yr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.pipe_busy  = s1_v_r | s2_v_r | s3_v_r;
  assign sts.shape_done = sh_done;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== design/ahob_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahob_ctrl
// Controller: request decode, harmonic count and issue, and sequencing of
// the mix, shaping and result steps. Holds the harmonic limit register.
// ----------------------------------------------------------------------------
module ahob_ctrl
  import ahob_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ahob_in_t           in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  ahob_sts_t          sts,
  output ahob_cmd_t          cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RUN   = 10'b0000000010,
    S_DRAIN = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_LEFT  = 10'b0000010000,
    S_SHL   = 10'b0000100000,
    S_WTL   = 10'b0001000000,
    S_SHR   = 10'b0010000000,
    S_WTR   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [KCNT_W-1:0]  lim_r, lim_nxt;
  logic [KCNT_W-1:0]  kcnt_r, kcnt_nxt;
  logic [DSTEP_W-1:0] dstep_r, dstep_nxt;
  logic [DSTEP_W-1:0] kd_r, kd_nxt;
  logic [31:0]        inc;
  logic [DSTEP_W-1:0] dstep_in;
  logic               accept;
  logic               can_issue;

  assign inc      = in_data.octave_down ? (in_data.phase_inc >> 1) : in_data.phase_inc;
  assign dstep_in = DSTEP_W'({inc[31:16], 3'b0}) + DSTEP_W'(inc[31:16]);
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_issue = (kcnt_r < lim_r) && (kd_r <= DSTEP_W'(ALIAS_NUM));

  always_comb begin
    state_nxt = state_r;
    lim_nxt   = lim_r;
    kcnt_nxt  = kcnt_r;
    dstep_nxt = dstep_r;
    kd_nxt    = kd_r;
    cmd       = '0;
    cmd.issue_idx = kcnt_r[HIDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_WRITE) begin
            cmd.amp_wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            lim_nxt   = (int'(limit_r) > MAX_HARMONICS) ? KCNT_W'(MAX_HARMONICS)
                                                        : KCNT_W'(limit_r);
            kcnt_nxt  = '0;
            dstep_nxt = dstep_in;
            kd_nxt    = dstep_in;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_issue) begin
          cmd.issue = 1'b1;
          kcnt_nxt  = kcnt_r + 1'b1;
          kd_nxt    = kd_r + dstep_r;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: if (!sts.pipe_busy) state_nxt = S_MUL;
      S_MUL: begin
        cmd.mix_mul = 1'b1;
        state_nxt   = S_LEFT;
      end
      S_LEFT: begin
        cmd.left_sel = 1'b1;
        state_nxt    = S_SHL;
      end
      S_SHL: begin
        cmd.shape_go = 1'b1;
        state_nxt    = S_WTL;
      end
      S_WTL: if (sts.shape_done) state_nxt = S_SHR;
      S_SHR: begin
        cmd.shape_go  = 1'b1;
        cmd.shape_sel = 1'b1;
        state_nxt     = S_WTR;
      end
      S_WTR: if (sts.shape_done) state_nxt = S_FIN;
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= LIMIT_W'(LIMIT_RESET);
      lim_r   <= '0;
      kcnt_r  <= '0;
      dstep_r <= '0;
      kd_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lim_r   <= lim_nxt;
      kcnt_r  <= kcnt_nxt;
      dstep_r <= dstep_nxt;
      kd_r    <= kd_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
    end
  end

endmodule

// ===== design/additive_harmonic_oscillator_bank.sv =====
`timescale 1ns / 1ps
// A sample request sums N harmonics (N at most 128); one harmonic enters
// the four-stage phase/sine/multiply/accumulate pipeline per cycle, and
// the two tanh evaluations share the one tanh unit and its divider.
// An amplitude write leaves the block idle and ready. No new request is
// taken until a sample's result has been loaded. Reset (synchronous,
// active low) restores the limit and the reset phases and amplitudes.
// ----------------------------------------------------------------------------
// additive_harmonic_oscillator_bank
// Additive oscillator bank with even/odd mixes and tanh output shaping.
// ----------------------------------------------------------------------------
module additive_harmonic_oscillator_bank
  import ahob_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ahob_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ahob_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  ahob_cmd_t cmd;
  ahob_sts_t sts;

  ahob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  ahob_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/ahob_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahob_checker
// Port-level checks for the oscillator bank, bound to the top level.
// ----------------------------------------------------------------------------
module ahob_checker
  import ahob_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ahob_in_t           in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ahob_out_t          out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [LIMIT_W-1:0] cfg_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An amplitude write finishes at once and leaves the block ready.
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_WRITE |=> in_ready)
    else $error("write request left the block busy");

  // A sample request keeps the block busy.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_SAMPLE |=> !in_ready)
    else $error("sample request did not occupy the block");

  // A new result only comes out of a sample in progress.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in progress");

endmodule

bind additive_harmonic_oscillator_bank ahob_checker u_ahob_checker (.*);
